@@ src/nbra_pkg.sv @@
// Shared widths, types and constants of the neighbour box run averager.
package nbra_pkg;

   localparam int COORD_BITS    = 12;
   localparam int MAX_RUN       = 4096;
   localparam int NUM_FIELDS    = 4;
   localparam int DIST_BITS     = 12;
   localparam int SIZE_BITS     = 13;
   localparam int SUM_BITS      = COORD_BITS + $clog2(MAX_RUN);
   localparam int CNT_BITS      = $clog2(MAX_RUN + 1);
   localparam int STEP_BITS     = $clog2(SUM_BITS);
   localparam int REQ_DATA_BITS = (NUM_FIELDS * COORD_BITS + 7) / 8 * 8;
   localparam int RSP_DATA_BITS = (NUM_FIELDS * COORD_BITS + SIZE_BITS + 7) / 8 * 8;

   localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(150);

   typedef logic [NUM_FIELDS-1:0][COORD_BITS-1:0] box_type;

   typedef struct packed {
      logic [NUM_FIELDS-1:0][SUM_BITS-1:0] sum;
      logic [CNT_BITS-1:0]                 count;
   } close_type;

   typedef struct packed {
      box_type              mean;
      logic [SIZE_BITS-1:0] size;
   } result_type;

endpackage

@@ src/neighbor_box_run_averager_top.sv @@
// Top level of the neighbour box run averager: ports, distance register, result register.
//
//   channel | dir | handshake               | content
//   req_    | in  | req_tvalid / req_tready | tuser start_frame, tdata box x,y,width,height
//   rsp_    | out | rsp_tvalid / rsp_tready | tdata mean x,y,width,height, run size
//   csr_    | in  | csr_we                  | csr_wdata neighbour distance
//
// A box that joins or opens a run is taken at once; boxes may follow back to back.
// A box that closes a run starts the bit-serial divider: req_tready drops while it works
// through the 24-bit sums bit by bit and then hands the quotient over, longer if the
// result register is still full. The divider shares one shift step over all four fields.
// Synchronous active-high reset empties the run and sets the distance to 150.
// A result waits in the output register until taken; boxes enter while the divider idles.
module neighbor_box_run_averager_top
   import nbra_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tuser,  // start_frame
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // box_x, box_y, box_width, box_height
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // mean_x, mean_y, mean_width, mean_height,
                                                // run_size, zero fill
   input  logic                     csr_we,
   input  logic [DIST_BITS-1:0]     csr_wdata   // neighbor_distance
);

   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff, rsp_data_in;

   logic       in_take;
   box_type    box;
   logic       close_valid;
   close_type  close;
   logic       div_busy;
   logic       done_valid;
   logic       done_take;
   result_type done;

   // box fields sit lowest first in the transfer
   always_comb begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
         box[i] = req_tdata[i*COORD_BITS +: COORD_BITS];
      end
   end

   // no boxes are taken while a closed run is being divided
   assign req_tready = !div_busy;
   assign in_take    = req_tvalid && req_tready;

   nbra_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .in_take     (in_take),
      .start_frame (req_tuser),
      .box         (box),
      .distance    (dist_ff),
      .close_valid (close_valid),
      .close       (close)
   );

   nbra_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (close_valid),
      .close      (close),
      .busy       (div_busy),
      .done_valid (done_valid),
      .done_take  (done_take),
      .done       (done)
   );

   // hand the quotient over when the output register is free or draining
   assign done_take = done_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      dist_in      = csr_we ? csr_wdata : dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff      <= DIST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         rsp_tdata[i*COORD_BITS +: COORD_BITS] = rsp_data_ff.mean[i];
      end
      rsp_tdata[NUM_FIELDS*COORD_BITS +: SIZE_BITS] = rsp_data_ff.size;
   end

endmodule

@@ src/nbra_accum.sv @@
// Run tracker: neighbour test, running sums and run close detection.
module nbra_accum
   import nbra_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_take,
   input  logic                 start_frame,
   input  box_type              box,
   input  logic [DIST_BITS-1:0] distance,
   output logic                 close_valid,
   output close_type            close
);

   logic                                run_open_ff, run_open_in;
   box_type                             prev_ff, prev_in;
   logic [NUM_FIELDS-1:0][SUM_BITS-1:0] sum_ff, sum_in;
   logic [CNT_BITS-1:0]                 count_ff, count_in;
   logic [NUM_FIELDS-1:0]               field_near;
   logic                                near;
   logic                                fresh;

   always_comb begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
         logic [COORD_BITS-1:0] diff;
         diff = (prev_ff[i] >= box[i]) ? prev_ff[i] - box[i] : box[i] - prev_ff[i];
         field_near[i] = diff < distance;
      end
   end

   assign fresh = start_frame || !run_open_ff;
   assign near  = (&field_near) && (count_ff < CNT_BITS'(MAX_RUN));

   always_comb begin
      run_open_in = run_open_ff;
      prev_in     = prev_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      close_valid = 1'b0;
      close.sum   = sum_ff;
      close.count = count_ff;
      if (in_take) begin
         prev_in     = box;
         run_open_in = 1'b1;
         if (!fresh && near) begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
               sum_in[i] = sum_ff[i] + SUM_BITS'(box[i]);
            end
            count_in = count_ff + CNT_BITS'(1);
         end else begin
            close_valid = !fresh;
            for (int i = 0; i < NUM_FIELDS; i++) begin
               sum_in[i] = SUM_BITS'(box[i]);
            end
            count_in = CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         prev_ff     <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         run_open_ff <= run_open_in;
         prev_ff     <= prev_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

endmodule

@@ src/nbra_divider.sv @@
// Bit-serial restoring divider: four run sums by the run count, one quotient bit a cycle.
module nbra_divider
   import nbra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  close_type  close,
   output logic       busy,
   output logic       done_valid,
   input  logic       done_take,
   output result_type done
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [STEP_BITS-1:0]                step_ff, step_in;
   logic [CNT_BITS-1:0]                 divisor_ff, divisor_in;
   logic [NUM_FIELDS-1:0][SUM_BITS-1:0] quo_ff, quo_in;
   logic [NUM_FIELDS-1:0][CNT_BITS-1:0] rem_ff, rem_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_RUN;
               step_in    = '0;
               divisor_in = close.count;
               quo_in     = close.sum;
               rem_in     = '0;
            end
         end
         ST_RUN: begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
               logic [CNT_BITS:0] trial;
               logic              ge;
               trial     = {rem_ff[i], quo_ff[i][SUM_BITS-1]};
               ge        = trial >= {1'b0, divisor_ff};
               rem_in[i] = ge ? CNT_BITS'(trial - {1'b0, divisor_ff}) : trial[CNT_BITS-1:0];
               quo_in[i] = {quo_ff[i][SUM_BITS-2:0], ge};
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign done_valid = state_ff == ST_HOLD;

   always_comb begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
         done.mean[i] = quo_ff[i][COORD_BITS-1:0];
      end
      done.size = SIZE_BITS'(divisor_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
   end

endmodule

@@ src/nbra_checker.sv @@
// Port-level checker for the neighbour box run averager, bound to the top level.
module nbra_checker
   import nbra_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int SIZE_LSB = NUM_FIELDS * COORD_BITS;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a closed run always holds at least one box
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[SIZE_LSB +: SIZE_BITS] != '0)
      else $error("result with empty run");

   // a result only appears after the divider has held off input
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result without division");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind neighbor_box_run_averager_top nbra_checker u_checker (.*);
